// ----- rtl/core/clock_event_flag_scheduler_core_assert.svh -----
// Assertion macros shared by the clock event flag scheduler RTL.
// Depends on nothing; each use names its own clock and active-low reset.
`ifndef CLOCK_EVENT_FLAG_SCHEDULER_CORE_ASSERT_SVH
`define CLOCK_EVENT_FLAG_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CEFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CEFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/cefs_pkg.sv -----
// Shared types and constants of the clock event flag scheduler.
// No dependencies.
package cefs_pkg;

	// Request commands
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	localparam int FLAG_NUM = 37;
	localparam logic [5:0] FLAG_COUNT   = 6'd37;
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [4:0] NO_HOUR      = 5'd31;
	localparam logic [5:0] NO_MINUTE    = 6'd63;

	// Flag positions
	localparam logic [5:0] FLAG_QUARTER = 6'd24;
	localparam logic [5:0] FLAG_HALF    = 6'd25;
	localparam logic [5:0] FLAG_HOUR1   = 6'd26;
	localparam logic [5:0] FLAG_HOUR2   = 6'd27;
	localparam logic [5:0] FLAG_HOUR3   = 6'd28;
	localparam logic [5:0] FLAG_HOUR4   = 6'd29;
	localparam logic [5:0] FLAG_HOUR8   = 6'd30;
	localparam logic [5:0] FLAG_HOUR12  = 6'd31;
	localparam logic [5:0] FLAG_DAY1    = 6'd32;
	localparam logic [5:0] FLAG_DAY2    = 6'd33;
	localparam logic [5:0] FLAG_DAY7    = 6'd34;
	localparam logic [5:0] FLAG_DAY14   = 6'd35;
	localparam logic [5:0] FLAG_DAY30   = 6'd36;

	// Minute marks
	localparam logic [5:0] MIN_00 = 6'd0;
	localparam logic [5:0] MIN_15 = 6'd15;
	localparam logic [5:0] MIN_30 = 6'd30;
	localparam logic [5:0] MIN_45 = 6'd45;

	// Last count value of each modulo counter (period minus one)
	localparam logic       LAST_2H  = 1'd1;
	localparam logic [1:0] LAST_3H  = 2'd2;
	localparam logic [1:0] LAST_4H  = 2'd3;
	localparam logic [2:0] LAST_8H  = 3'd7;
	localparam logic [3:0] LAST_12H = 4'd11;
	localparam logic       LAST_2D  = 1'd1;
	localparam logic [2:0] LAST_7D  = 3'd6;
	localparam logic [3:0] LAST_14D = 4'd13;
	localparam logic [4:0] LAST_30D = 5'd29;

	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] flag_index;
		logic       flag_value;
	} req_t;

	typedef struct packed {
		logic [FLAG_NUM-1:0] all_flags;
		logic                selected_flag;
	} res_t;

endpackage

// ----- rtl/core/cefs_state.sv -----
// Flag and counter state of the scheduler with its next-state logic.
// Depends on cefs_pkg and clock_event_flag_scheduler_core_assert.svh.
`include "clock_event_flag_scheduler_core_assert.svh"

module cefs_state (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cefs_pkg::req_t req,
	output cefs_pkg::res_t res
);

	logic [cefs_pkg::FLAG_NUM-1:0] flags_q, flags_n, set_mask;
	logic [4:0] last_hour_q;
	logic [5:0] last_minute_q;
	logic       first_hour_pending_q;
	logic       cnt2h_q, cnt2h_n;
	logic [1:0] cnt3h_q, cnt3h_n;
	logic [1:0] cnt4h_q, cnt4h_n;
	logic [2:0] cnt8h_q, cnt8h_n;
	logic [3:0] cnt12h_q, cnt12h_n;
	logic       cnt2d_q, cnt2d_n;
	logic [2:0] cnt7d_q, cnt7d_n;
	logic [3:0] cnt14d_q, cnt14d_n;
	logic [4:0] cnt30d_q, cnt30d_n;

	logic is_sample, hour_chg, min_chg, new_hour, new_day, idx_ok;
	logic wrap2h, wrap3h, wrap4h, wrap8h, wrap12h;
	logic wrap2d, wrap7d, wrap14d, wrap30d;

	// Event detection
	assign is_sample = (req.cmd == cefs_pkg::CMD_SAMPLE);
	assign hour_chg  = is_sample && (req.hour != last_hour_q);
	assign min_chg   = is_sample && (req.minute != last_minute_q);
	assign new_hour  = hour_chg && !first_hour_pending_q;
	assign new_day   = new_hour && (req.hour == 5'd0);
	assign idx_ok    = (req.flag_index < cefs_pkg::FLAG_COUNT);

	// Modulo counters: wrap detect and next value
	assign wrap2h  = (cnt2h_q == cefs_pkg::LAST_2H);
	assign wrap3h  = (cnt3h_q == cefs_pkg::LAST_3H);
	assign wrap4h  = (cnt4h_q == cefs_pkg::LAST_4H);
	assign wrap8h  = (cnt8h_q == cefs_pkg::LAST_8H);
	assign wrap12h = (cnt12h_q == cefs_pkg::LAST_12H);
	assign wrap2d  = (cnt2d_q == cefs_pkg::LAST_2D);
	assign wrap7d  = (cnt7d_q == cefs_pkg::LAST_7D);
	assign wrap14d = (cnt14d_q == cefs_pkg::LAST_14D);
	assign wrap30d = (cnt30d_q == cefs_pkg::LAST_30D);

	assign cnt2h_n  = !new_hour ? cnt2h_q  : (wrap2h  ? 1'd0 : cnt2h_q + 1'd1);
	assign cnt3h_n  = !new_hour ? cnt3h_q  : (wrap3h  ? 2'd0 : cnt3h_q + 2'd1);
	assign cnt4h_n  = !new_hour ? cnt4h_q  : (wrap4h  ? 2'd0 : cnt4h_q + 2'd1);
	assign cnt8h_n  = !new_hour ? cnt8h_q  : (wrap8h  ? 3'd0 : cnt8h_q + 3'd1);
	assign cnt12h_n = !new_hour ? cnt12h_q : (wrap12h ? 4'd0 : cnt12h_q + 4'd1);
	assign cnt2d_n  = !new_day  ? cnt2d_q  : (wrap2d  ? 1'd0 : cnt2d_q + 1'd1);
	assign cnt7d_n  = !new_day  ? cnt7d_q  : (wrap7d  ? 3'd0 : cnt7d_q + 3'd1);
	assign cnt14d_n = !new_day  ? cnt14d_q : (wrap14d ? 4'd0 : cnt14d_q + 4'd1);
	assign cnt30d_n = !new_day  ? cnt30d_q : (wrap30d ? 5'd0 : cnt30d_q + 5'd1);

	// Flags raised by a clock sample
	always_comb begin
		set_mask = '0;
		if (new_hour) begin
			set_mask[cefs_pkg::FLAG_HOUR1]  = 1'b1;
			set_mask[cefs_pkg::FLAG_HOUR2]  = wrap2h;
			set_mask[cefs_pkg::FLAG_HOUR3]  = wrap3h;
			set_mask[cefs_pkg::FLAG_HOUR4]  = wrap4h;
			set_mask[cefs_pkg::FLAG_HOUR8]  = wrap8h;
			set_mask[cefs_pkg::FLAG_HOUR12] = wrap12h;
			if (req.hour < cefs_pkg::HOURS_PER_DAY) begin
				set_mask[{1'b0, req.hour}] = 1'b1;
			end
		end
		if (new_day) begin
			set_mask[cefs_pkg::FLAG_DAY1]  = 1'b1;
			set_mask[cefs_pkg::FLAG_DAY2]  = wrap2d;
			set_mask[cefs_pkg::FLAG_DAY7]  = wrap7d;
			set_mask[cefs_pkg::FLAG_DAY14] = wrap14d;
			set_mask[cefs_pkg::FLAG_DAY30] = wrap30d;
		end
		if (min_chg) begin
			if (req.minute == cefs_pkg::MIN_00 || req.minute == cefs_pkg::MIN_15 ||
			    req.minute == cefs_pkg::MIN_30 || req.minute == cefs_pkg::MIN_45) begin
				set_mask[cefs_pkg::FLAG_QUARTER] = 1'b1;
			end
			if (req.minute == cefs_pkg::MIN_00 || req.minute == cefs_pkg::MIN_30) begin
				set_mask[cefs_pkg::FLAG_HALF] = 1'b1;
			end
		end
	end

	// Command decode into next flag vector
	always_comb begin
		flags_n = flags_q;
		unique case (req.cmd)
			cefs_pkg::CMD_SAMPLE: flags_n = flags_q | set_mask;
			cefs_pkg::CMD_READ:   flags_n = flags_q;
			cefs_pkg::CMD_CLEAR: begin
				if (idx_ok) flags_n[req.flag_index] = 1'b0;
			end
			cefs_pkg::CMD_WRITE: begin
				if (idx_ok) flags_n[req.flag_index] = req.flag_value;
			end
		endcase
	end

	assign res.all_flags     = flags_n;
	assign res.selected_flag = idx_ok ? flags_n[req.flag_index] : 1'b0;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q              <= '0;
			last_hour_q          <= cefs_pkg::NO_HOUR;
			last_minute_q        <= cefs_pkg::NO_MINUTE;
			first_hour_pending_q <= 1'b1;
			cnt2h_q              <= '0;
			cnt3h_q              <= '0;
			cnt4h_q              <= '0;
			cnt8h_q              <= '0;
			cnt12h_q             <= '0;
			cnt2d_q              <= '0;
			cnt7d_q              <= '0;
			cnt14d_q             <= '0;
			cnt30d_q             <= '0;
		end else if (en) begin
			flags_q  <= flags_n;
			cnt2h_q  <= cnt2h_n;
			cnt3h_q  <= cnt3h_n;
			cnt4h_q  <= cnt4h_n;
			cnt8h_q  <= cnt8h_n;
			cnt12h_q <= cnt12h_n;
			cnt2d_q  <= cnt2d_n;
			cnt7d_q  <= cnt7d_n;
			cnt14d_q <= cnt14d_n;
			cnt30d_q <= cnt30d_n;
			if (hour_chg) begin
				last_hour_q          <= req.hour;
				first_hour_pending_q <= 1'b0;
			end
			if (min_chg) last_minute_q <= req.minute;
		end
	end

	`CEFS_ASSERT_NEXT(a_hour_tracked, clk, arst_n, en && is_sample,
		last_hour_q == $past(req.hour), "last hour not updated by clock sample")
	`CEFS_ASSERT_NEXT(a_hour_flag, clk, arst_n, en && new_hour,
		flags_q[cefs_pkg::FLAG_HOUR1], "every-hour flag not set on new hour")
	`CEFS_ASSERT_NEXT(a_clear_works, clk, arst_n,
		en && req.cmd == cefs_pkg::CMD_CLEAR && idx_ok,
		!flags_q[$past(req.flag_index)], "cleared flag still set")
	`CEFS_ASSERT_NEXT(a_hold_idle, clk, arst_n, !en,
		$stable(flags_q) && $stable(cnt12h_q) && $stable(cnt30d_q),
		"state changed without a request")

endmodule

// ----- rtl/core/clock_event_flag_scheduler_core.sv -----
// Clock event flag scheduler: input register, flag state update, result register.
// A request waits in the input register; its result is then registered for m_tdata.
// Throughput: one request per cycle unless stalled; flag/counter update is combinational.
// Backpressure on m_tready holds the result register, then the input register.
// Reset (arst_n low, asynchronous): flags and counters zero, no hour or minute seen.
// Depends on cefs_pkg, cefs_state and clock_event_flag_scheduler_core_assert.svh.
`include "clock_event_flag_scheduler_core_assert.svh"

module clock_event_flag_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // hour[4:0], minute[10:5], flag_index[16:11],
	                               // flag_value[17], zero[23:18]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // selected_flag[0], all_flags[37:1], zero[39:38]
);

	cefs_pkg::req_t req_in, req_s1;
	cefs_pkg::res_t res_comb, res_q;
	logic           valid_s1;
	logic           m_tvalid_q;
	logic           advance;

	// Unpack the incoming request
	assign req_in.cmd        = cefs_pkg::cmd_t'(s_tuser);
	assign req_in.hour       = s_tdata[4:0];
	assign req_in.minute     = s_tdata[10:5];
	assign req_in.flag_index = s_tdata[16:11];
	assign req_in.flag_value = s_tdata[17];

	// Stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) req_s1 <= req_in;
	end

	cefs_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.res    (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_comb;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.all_flags, res_q.selected_flag};

	`CEFS_ASSERT_NEXT(a_take_fills_s1, clk, arst_n, s_tvalid && s_tready, valid_s1,
		"accepted request missing from input register")
	`CEFS_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(req_s1), "stalled request lost from input register")
	`CEFS_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, advance, m_tvalid_q,
		"processed request produced no result")

endmodule

// ----- sim/clock_event_flag_scheduler_core_test.sv -----
// Testbench for clock_event_flag_scheduler_core: directed table, then random clock walks.
// Results are checked against an in-bench model of the flag and counter state.
// Depends on cefs_pkg and the core RTL.
module clock_event_flag_scheduler_core_test;
	import cefs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // hour[4:0], minute[10:5], flag_index[16:11],
	                             // flag_value[17], zero[23:18]
	logic [1:0]  s_tuser = '0;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // selected_flag[0], all_flags[37:1], zero[39:38]

	clock_event_flag_scheduler_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	typedef struct {
		req_t rq;
		bit   fixed;
		res_t want;
	} dir_row_t;

	// Model state
	logic [FLAG_NUM-1:0] event_bits;
	logic [4:0]          seen_hour;
	logic [5:0]          seen_minute;
	logic                hour_pending;
	logic                cnt_2h;
	logic [1:0]          cnt_3h;
	logic [1:0]          cnt_4h;
	logic [2:0]          cnt_8h;
	logic [3:0]          cnt_12h;
	logic                cnt_2d;
	logic [2:0]          cnt_7d;
	logic [3:0]          cnt_14d;
	logic [4:0]          cnt_30d;

	res_t     flags_expected[$];
	res_t     got_res;
	res_t     want_res;
	dir_row_t dir_rows[$];
	int       errors = 0;
	int       results_seen = 0;
	bit       hold_off = 1'b0;
	bit       quiet = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit, far above the slowest legal run
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Modulo counter step; raises the flag on wrap
	function automatic int tick(int cnt, int period, logic [5:0] pos);
		if (cnt + 1 >= period) begin
			event_bits[pos] = 1'b1;
			return 0;
		end
		return cnt + 1;
	endfunction

	// Apply one request to the model, return the result it should produce
	function automatic res_t predict_flags(req_t rq);
		res_t r;
		bit   idx_ok;
		idx_ok = rq.flag_index < FLAG_COUNT;
		case (rq.cmd)
			CMD_SAMPLE: begin
				// hour check comes first, then minute
				if (rq.hour != seen_hour) begin
					seen_hour = rq.hour;
					if (hour_pending) begin
						hour_pending = 1'b0;
					end else begin
						event_bits[FLAG_HOUR1] = 1'b1;
						cnt_2h  = 1'(tick(cnt_2h, 2, FLAG_HOUR2));
						cnt_3h  = 2'(tick(cnt_3h, 3, FLAG_HOUR3));
						cnt_4h  = 2'(tick(cnt_4h, 4, FLAG_HOUR4));
						cnt_8h  = 3'(tick(cnt_8h, 8, FLAG_HOUR8));
						cnt_12h = 4'(tick(cnt_12h, 12, FLAG_HOUR12));
						if (rq.hour < HOURS_PER_DAY) begin
							event_bits[rq.hour] = 1'b1;
							if (rq.hour == 5'd0) begin
								event_bits[FLAG_DAY1] = 1'b1;
								cnt_2d  = 1'(tick(cnt_2d, 2, FLAG_DAY2));
								cnt_7d  = 3'(tick(cnt_7d, 7, FLAG_DAY7));
								cnt_14d = 4'(tick(cnt_14d, 14, FLAG_DAY14));
								cnt_30d = 5'(tick(cnt_30d, 30, FLAG_DAY30));
							end
						end
					end
				end
				if (rq.minute != seen_minute) begin
					seen_minute = rq.minute;
					if (rq.minute == MIN_00 || rq.minute == MIN_15 ||
					    rq.minute == MIN_30 || rq.minute == MIN_45)
						event_bits[FLAG_QUARTER] = 1'b1;
					if (rq.minute == MIN_00 || rq.minute == MIN_30)
						event_bits[FLAG_HALF] = 1'b1;
				end
			end
			CMD_CLEAR: if (idx_ok) event_bits[rq.flag_index] = 1'b0;
			CMD_WRITE: if (idx_ok) event_bits[rq.flag_index] = rq.flag_value;
			default: ;
		endcase
		r.all_flags     = event_bits;
		r.selected_flag = idx_ok ? event_bits[rq.flag_index] : 1'b0;
		return r;
	endfunction

	function automatic dir_row_t mk_row(cmd_t c, int h, int m, int idx, bit v,
	                                    bit fixed, bit sel, logic [FLAG_NUM-1:0] fl);
		dir_row_t d;
		d.rq.cmd                = c;
		d.rq.hour               = 5'(h);
		d.rq.minute             = 6'(m);
		d.rq.flag_index         = 6'(idx);
		d.rq.flag_value         = v;
		d.fixed                 = fixed;
		d.want.selected_flag    = sel;
		d.want.all_flags        = fl;
		return d;
	endfunction

	// Short gaps mostly, a few long ones; none during quiet stretches or hold-off
	function automatic int pick_gap();
		int r;
		if (hold_off || quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one request, queue its expected result once accepted
	task automatic offer(req_t rq, res_t want);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= rq.cmd;
		s_tdata  <= {6'd0, rq.flag_value, rq.flag_index, rq.minute, rq.hour};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		flags_expected.push_back(want);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Reset once
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result side: random ready, plus one long hold-off to back the block up
	initial begin : drain
		int  n;
		bit  pressed;
		pressed = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!pressed && results_seen >= 120) begin
				pressed  = 1'b1;
				hold_off = 1'b1;
				m_tready <= 1'b0;
				repeat (64) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				m_tready <= 1'b1;
				n = $urandom_range(1, 30);
				repeat (n) @(posedge clk);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got_res.selected_flag = m_tdata[0];
			got_res.all_flags     = m_tdata[FLAG_NUM:1];
			if (flags_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
			end else begin
				want_res = flags_expected.pop_front();
				if (got_res.selected_flag !== want_res.selected_flag) begin
					errors++;
					$display("%0t: selected_flag expected %b actual %b", $time,
					         want_res.selected_flag, got_res.selected_flag);
				end
				if (got_res.all_flags !== want_res.all_flags) begin
					errors++;
					$display("%0t: all_flags expected %h actual %h", $time,
					         want_res.all_flags, got_res.all_flags);
				end
			end
		end
	end

	// Request side
	initial begin : feed
		req_t rq;
		res_t p;
		int   k;
		int   r;
		int   wall_hour;
		int   wall_min;

		event_bits   = '0;
		seen_hour    = NO_HOUR;
		seen_minute  = NO_MINUTE;
		hour_pending = 1'b1;
		cnt_2h = '0; cnt_3h = '0; cnt_4h = '0; cnt_8h = '0; cnt_12h = '0;
		cnt_2d = '0; cnt_7d = '0; cnt_14d = '0; cnt_30d = '0;

		// Directed table; fixed rows carry the value known from reset state
		dir_rows.push_back(mk_row(CMD_READ,   0,  0,  0, 0, 1, 0, '0));
		dir_rows.push_back(mk_row(CMD_READ,   0,  0, 40, 1, 1, 0, '0));
		// no hour or minute seen yet: 31/63 is no change
		dir_rows.push_back(mk_row(CMD_SAMPLE, 31, 63, 63, 1, 1, 0, '0));
		// first hour change only recorded; minute 7 is no mark
		dir_rows.push_back(mk_row(CMD_SAMPLE, 5,  7,  0, 0, 1, 0, '0));
		dir_rows.push_back(mk_row(CMD_SAMPLE, 6, 15,  6, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_READ,   0,  0, 36, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_WRITE,  0,  0, 36, 1, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_READ,  31, 63, 36, 1, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_WRITE,  0,  0, 63, 1, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_CLEAR,  0,  0, 37, 0, 0, 0, '0));
		// clear twice: stays zero, never toggles
		dir_rows.push_back(mk_row(CMD_CLEAR,  0,  0, 36, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_CLEAR,  0,  0, 36, 1, 0, 0, '0));
		// midnight with hour and minute firing in the same request
		dir_rows.push_back(mk_row(CMD_SAMPLE, 0,  0, 32, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_SAMPLE, 0, 30, 25, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_SAMPLE, 0, 45, 24, 0, 0, 0, '0));
		// out-of-range hour and minute
		dir_rows.push_back(mk_row(CMD_SAMPLE, 24, 60, 26, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_SAMPLE, 31, 63, 31, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_SAMPLE, 23, 59, 23, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_WRITE,  0,  0,  0, 1, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_WRITE,  0,  0,  0, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_CLEAR,  0,  0, 24, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_SAMPLE, 0,  0, 33, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(CMD_READ,   0,  0, 63, 0, 0, 0, '0));

		@(posedge clk);
		while (!arst_n)
			@(posedge clk);

		foreach (dir_rows[i]) begin
			p = predict_flags(dir_rows[i].rq);
			offer(dir_rows[i].rq, dir_rows[i].fixed ? dir_rows[i].want : p);
		end

		// Random part: mostly a walking wall clock, with flag accesses and noise
		wall_hour = 0;
		wall_min  = 0;
		for (int n = 0; n < 550; n++) begin
			quiet = (n >= 300 && n < 360);
			r = $urandom_range(0, 99);
			rq.hour       = 5'($urandom_range(0, 31));
			rq.minute     = 6'($urandom_range(0, 63));
			rq.flag_index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(37, 63))
			                                            : 6'($urandom_range(0, 36));
			rq.flag_value = 1'($urandom_range(0, 1));
			if (r < 55) begin
				rq.cmd = CMD_SAMPLE;
				k = $urandom_range(0, 11);
				if (k < 5) begin
					wall_min += $urandom_range(1, 20);
					if (wall_min >= 60) begin
						wall_min  -= 60;
						wall_hour = (wall_hour + 1) % 24;
					end
					if ($urandom_range(0, 2) == 0)
						wall_min = 15 * $urandom_range(0, 3);
				end else if (k < 7) begin
					wall_hour = (wall_hour + 1) % 24;
					wall_min  = $urandom_range(0, 59);
				end else if (k < 10) begin
					// bounce across midnight to run the day counters
					wall_hour = (wall_hour == 0) ? 23 : 0;
					wall_min  = 0;
				end
				rq.hour   = 5'(wall_hour);
				rq.minute = 6'(wall_min);
			end else if (r < 65) begin
				rq.cmd = CMD_READ;
			end else if (r < 80) begin
				rq.cmd = CMD_CLEAR;
			end else if (r < 92) begin
				rq.cmd = CMD_WRITE;
			end else begin
				rq.cmd        = cmd_t'($urandom_range(0, 3));
				rq.flag_index = 6'($urandom_range(0, 63));
			end
			p = predict_flags(rq);
			offer(rq, p);
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		while (flags_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
